// ----- sv/pcac_pkg.sv -----
// pcac_pkg: shared types and constants for the people counter alarm controller
// no dependencies; imported by pcac_core and the top level
package pcac_pkg;

    typedef enum logic [3:0] {
        OP_POLL      = 4'd0,
        OP_BEAM      = 4'd1,
        OP_MODE      = 4'd2,
        OP_DOWN      = 4'd3,
        OP_UP        = 4'd4,
        OP_LINK_UP   = 4'd5,
        OP_LINK_DOWN = 4'd6,
        OP_CLEAR     = 4'd7,
        OP_ALERT     = 4'd8
    } op_t;

    localparam int unsigned CfgIndexWidth = 2;
    localparam int unsigned CfgDataWidth  = 16;

    localparam logic [CfgIndexWidth-1:0] CFG_DEBOUNCE_MS    = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_ALARM_MS       = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_MOTION_QUALIFY = 2'd2;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd200;
    localparam logic [15:0] ALARM_RESET    = 16'd5000;
    localparam logic [3:0]  QUALIFY_RESET  = 4'd5;
    localparam logic [6:0]  LIMIT_RESET    = 7'd5;
    localparam logic [6:0]  LIMIT_STEP     = 7'd10;
    localparam logic [6:0]  LIMIT_TOP      = 7'd100;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] time_ms;
        logic        motion_level;
    } in_t;

    typedef struct packed {
        logic [15:0] people;
        logic [6:0]  limit;
        logic        in_setting;
        logic        alarm_on;
        logic        link_up;
        logic        warn_pulse;
        logic        save_pulse;
    } out_t;

    typedef struct packed {
        logic                     we;
        logic [CfgIndexWidth-1:0] index;
        logic [CfgDataWidth-1:0]  wdata;
    } cfg_wr_t;

endpackage

// ----- sv/pcac_core.sv -----
// pcac_core: configuration registers, controller state and the per-event update
// depends on pcac_pkg
module pcac_core import pcac_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_wr_t cfg_wr,
    input  logic    step,
    input  in_t     item,
    output out_t    result
);

    logic [15:0] debounce_reg, alarm_ms_reg;
    logic [3:0]  qualify_reg;

    logic [15:0] count_reg, count_next;
    logic [6:0]  threshold_reg, threshold_next;
    logic        setting_reg, setting_next;
    logic [3:0]  run_reg, run_next;
    logic        motion_ok_reg, motion_ok_next;
    logic [31:0] last_time_reg, last_time_next;
    logic        alarm_reg, alarm_next;
    logic [31:0] alarm_start_reg, alarm_start_next;
    logic        alarm_done_reg, alarm_done_next;
    logic        link_reg, link_next;
    logic        warn, save;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
            alarm_ms_reg <= ALARM_RESET;
            qualify_reg  <= QUALIFY_RESET;
        end else if (cfg_wr.we) begin
            unique case (cfg_wr.index)
                CFG_DEBOUNCE_MS:    debounce_reg <= cfg_wr.wdata;
                CFG_ALARM_MS:       alarm_ms_reg <= cfg_wr.wdata;
                CFG_MOTION_QUALIFY: qualify_reg  <= cfg_wr.wdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [31:0] pin_gap;
        logic [31:0] alarm_gap;
        count_next       = count_reg;
        threshold_next   = threshold_reg;
        setting_next     = setting_reg;
        run_next         = run_reg;
        motion_ok_next   = motion_ok_reg;
        last_time_next   = last_time_reg;
        alarm_next       = alarm_reg;
        alarm_start_next = alarm_start_reg;
        alarm_done_next  = alarm_done_reg;
        link_next        = link_reg;
        warn             = 1'b0;
        save             = 1'b0;
        pin_gap          = item.time_ms - last_time_reg;
        alarm_gap        = item.time_ms - alarm_start_reg;

        case (item.op) inside
            OP_POLL: begin
                if (item.motion_level) begin
                    if (run_reg < qualify_reg) run_next = run_reg + 4'd1;
                    if (run_next >= qualify_reg) motion_ok_next = 1'b1;
                end else begin
                    run_next       = '0;
                    motion_ok_next = 1'b0;
                end
                // one-shot start, else the end check on the registered alarm
                if (count_reg > {9'd0, threshold_reg} && !alarm_reg && !alarm_done_reg) begin
                    alarm_next       = 1'b1;
                    alarm_start_next = item.time_ms;
                    alarm_done_next  = 1'b1;
                    warn             = 1'b1;
                end else if (alarm_reg && alarm_gap > {16'd0, alarm_ms_reg}) begin
                    alarm_next = 1'b0;
                end
            end
            OP_BEAM, OP_MODE, OP_DOWN, OP_UP: begin
                if (pin_gap > {16'd0, debounce_reg}) begin
                    last_time_next = item.time_ms;
                    case (item.op)
                        OP_BEAM: begin
                            if (motion_ok_reg && !setting_reg && count_reg != COUNT_MAX)
                                count_next = count_reg + 16'd1;
                        end
                        OP_MODE: begin
                            save         = setting_reg;
                            setting_next = !setting_reg;
                        end
                        OP_DOWN: begin
                            if (setting_reg) begin
                                threshold_next = (threshold_reg < LIMIT_STEP) ? LIMIT_TOP
                                               : threshold_reg - LIMIT_STEP;
                            end else begin
                                count_next      = '0;
                                alarm_done_next = 1'b0;
                            end
                        end
                        default: begin
                            if (setting_reg)
                                threshold_next = (threshold_reg < LIMIT_TOP)
                                               ? threshold_reg + LIMIT_STEP : 7'd0;
                        end
                    endcase
                end
            end
            OP_LINK_UP:   link_next = 1'b1;
            OP_LINK_DOWN: link_next = 1'b0;
            OP_CLEAR: begin
                count_next      = '0;
                alarm_done_next = 1'b0;
            end
            OP_ALERT: begin
                alarm_next       = 1'b1;
                alarm_start_next = item.time_ms;
                alarm_done_next  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            threshold_reg   <= LIMIT_RESET;
            setting_reg     <= 1'b0;
            run_reg         <= '0;
            motion_ok_reg   <= 1'b0;
            last_time_reg   <= '0;
            alarm_reg       <= 1'b0;
            alarm_start_reg <= '0;
            alarm_done_reg  <= 1'b0;
            link_reg        <= 1'b0;
        end else if (step) begin
            count_reg       <= count_next;
            threshold_reg   <= threshold_next;
            setting_reg     <= setting_next;
            run_reg         <= run_next;
            motion_ok_reg   <= motion_ok_next;
            last_time_reg   <= last_time_next;
            alarm_reg       <= alarm_next;
            alarm_start_reg <= alarm_start_next;
            alarm_done_reg  <= alarm_done_next;
            link_reg        <= link_next;
        end
    end

    assign result = '{
        people:     count_next,
        limit:      threshold_next,
        in_setting: setting_next,
        alarm_on:   alarm_next,
        link_up:    link_next,
        warn_pulse: warn,
        save_pulse: save
    };

endmodule

// ----- sv/people_counter_alarm_controller_unit.sv -----
// people counter alarm controller, top level: input register, update core, result register
// depends on pcac_pkg and pcac_core
// a transaction accepted into the input register updates state in pcac_core and is then held in the result register
// throughput: one transaction per cycle unless a result waits for m_ready; pcac_core updates its state on each advance
// a result waiting for m_ready holds the next event in the input register,
// and s_ready drops once both registers are full and m_ready is low
// reset: synchronous active-low aresetn empties both registers and restores state
module people_counter_alarm_controller_unit import pcac_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration write port
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_wdata,
    // event channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_t                      s_data,
    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_t                     m_data
);

    // input register holding one event transaction
    logic in_valid_reg;
    in_t  in_data_reg;

    // result register
    logic out_valid_reg;
    out_t out_data_reg;

    logic    advance;   // event leaves the input register and updates state
    out_t    result;
    cfg_wr_t cfg_wr;

    // result register can take a new result when empty or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    // input register frees up when empty or when its event moves on
    assign s_ready = !in_valid_reg || !out_valid_reg || m_ready;

    assign cfg_wr = '{we: cfg_we, index: cfg_index, wdata: cfg_wdata};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    pcac_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_wr  (cfg_wr),
        .step    (advance),
        .item    (in_data_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
